// ===== rtl/rcd_pkg.sv =====
`default_nettype none

package rcd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 32;
    localparam int BASE_BITS  = 5;
    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 7;

    localparam int COUNT_BITS = $clog2(MAX_DIGITS + 1);
    localparam int IDX_BITS   = $clog2(MAX_DIGITS);

    // long division: STEP_BITS quotient bits per cycle
    localparam int STEP_BITS  = 8;
    localparam int DIV_W      = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int PASSES     = DIV_W / STEP_BITS;
    localparam int PASS_BITS  = (PASSES > 1) ? $clog2(PASSES) : 1;

    localparam logic [BASE_BITS-1:0] BASE_MIN     = BASE_BITS'(2);
    localparam logic [BASE_BITS-1:0] BASE_MAX     = BASE_BITS'(16);
    localparam logic [BASE_BITS-1:0] BASE_DEFAULT = BASE_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = CHAR_BITS'(65);

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_en;
    } rcd_ctrl_t;

    typedef struct packed {
        logic pass_last;
        logic quot_zero;
        logic count_full;
    } rcd_status_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = CHAR_BITS'(d);
        if (d < DIGIT_BITS'(10))
            return CHAR_ZERO + dx;
        else
            return CHAR_ALPHA + dx - CHAR_BITS'(10);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rcd_datapath.sv =====
`default_nettype none

module rcd_datapath
    import rcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rcd_ctrl_t             ctrl,
    output rcd_status_t                status,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [BASE_BITS-1:0]  base,
    output logic [CHAR_BITS-1:0]       digit_char,
    output logic                       last_digit
);

    logic [DIV_W-1:0]      quot_reg;
    logic [DIGIT_BITS-1:0] rem_reg;
    logic [BASE_BITS-1:0]  radix_reg;
    logic [PASS_BITS-1:0]  pass_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [DIGIT_BITS-1:0] rd_digit_reg;
    logic                  last_reg;

    logic [DIGIT_BITS-1:0] digit_mem [MAX_DIGITS];

    logic [DIV_W-1:0]      quot_next;
    logic [DIGIT_BITS-1:0] rem_next;
    logic [BASE_BITS-1:0]  radix_fix;
    logic                  pass_last;
    logic [IDX_BITS-1:0]   wr_idx;
    logic [IDX_BITS-1:0]   rd_idx;
    logic [COUNT_BITS-1:0] count_dec;

    assign radix_fix = (base < BASE_MIN || base > BASE_MAX) ? BASE_DEFAULT : base;
    assign pass_last = (pass_reg == PASS_BITS'(PASSES - 1));
    assign count_dec = count_reg - COUNT_BITS'(1);
    assign wr_idx    = count_reg[IDX_BITS-1:0];
    assign rd_idx    = count_dec[IDX_BITS-1:0];

    // STEP_BITS restoring-division steps, MSB first
    always_comb
    begin
        logic [BASE_BITS-1:0] r;
        logic [STEP_BITS-1:0] q;
        r = BASE_BITS'(rem_reg);
        q = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r = {r[BASE_BITS-2:0], quot_reg[DIV_W-1-i]};
            if (r >= radix_reg)
            begin
                r = r - radix_reg;
                q[STEP_BITS-1-i] = 1'b1;
            end
        end
        rem_next = r[DIGIT_BITS-1:0];
        if (DIV_W > STEP_BITS)
            quot_next = {quot_reg[DIV_W-STEP_BITS-1:0], q};
        else
            quot_next = DIV_W'(q);
    end

    assign status.pass_last  = pass_last;
    assign status.quot_zero  = (quot_next == '0);
    assign status.count_full = (count_reg == COUNT_BITS'(MAX_DIGITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg  <= '0;
            count_reg <= '0;
            quot_reg  <= '0;
        end
        else if (ctrl.load)
        begin
            pass_reg  <= '0;
            count_reg <= '0;
            quot_reg  <= DIV_W'(value);
        end
        else if (ctrl.div_step)
        begin
            quot_reg <= quot_next;
            if (pass_last)
            begin
                pass_reg  <= '0;
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            else
            begin
                pass_reg <= pass_reg + PASS_BITS'(1);
            end
        end
        else if (ctrl.rd_en)
        begin
            count_reg <= count_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            radix_reg <= radix_fix;
            rem_reg   <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= pass_last ? '0 : rem_next;
        end
        if (ctrl.rd_en)
            last_reg <= (count_reg == COUNT_BITS'(1));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_step && pass_last)
            digit_mem[wr_idx] <= rem_next;
        if (ctrl.rd_en)
            rd_digit_reg <= digit_mem[rd_idx];
    end

    assign digit_char = digit_to_ascii(rd_digit_reg);
    assign last_digit = last_reg;

endmodule

`default_nettype wire

// ===== rtl/rcd_controller.sv =====
`default_nettype none

module rcd_controller
    import rcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire logic        out_last,
    input  wire rcd_status_t status,
    output rcd_ctrl_t        ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (status.pass_last && (status.quot_zero || status.count_full))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = out_last ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/radix_conversion_to_digits_core.sv =====
// Converts one value per beat into base-2..16 ASCII digits, most significant first.
// Steps: a load, then divider passes for each digit (8 quotient bits a cycle),
// then a store read and an output beat per emitted digit, plus any output stall.
// One item at a time: the input is not ready again until the last digit is taken.
// Reset: rst_n asynchronous active low, returns to idle; digit store is not cleared.
`default_nettype none

module radix_conversion_to_digits_core
    import rcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [30:0] value, [35:31] base
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] digit_char
    output logic             m_tlast    // last_digit
);

    rcd_ctrl_t             ctrl;
    rcd_status_t           status;
    logic [CHAR_BITS-1:0]  digit_char;
    logic                  last_digit;

    rcd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (last_digit),
        .status    (status),
        .ctrl      (ctrl)
    );

    rcd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .value      (s_tdata[VALUE_BITS-1:0]),
        .base       (s_tdata[VALUE_BITS+BASE_BITS-1:VALUE_BITS]),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    assign m_tdata = {1'b0, digit_char};
    assign m_tlast = last_digit;

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while a digit is pending");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accepting an item");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block not idle after last digit");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) ||
                      (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd70)))
        else $error("digit character out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/radix_conversion_to_digits_core_tb.sv =====
`timescale 1ns / 1ps

module radix_conversion_to_digits_core_tb;

    import rcd_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 200;
    localparam int STEADY_ITEMS = 40;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } digit_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [30:0] value, [35:31] base
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [6:0] digit_char
    logic        m_tlast;   // last_digit

    digit_beat_t digits_due[$];
    int          mismatches;
    int          cycle_count;
    bit          steady_flow;

    radix_conversion_to_digits_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // expected digits of one conversion, most significant first
    task automatic predict_digits(input logic [VALUE_BITS-1:0] value,
                                  input logic [BASE_BITS-1:0] base);
        logic [VALUE_BITS-1:0] quot;
        logic [BASE_BITS-1:0]  radix;
        logic [DIGIT_BITS-1:0] rems[$];
        logic [DIGIT_BITS-1:0] r;
        digit_beat_t           beat;
        radix = (base < BASE_MIN || base > BASE_MAX) ? BASE_DEFAULT : base;
        quot  = value;
        do
        begin
            rems.push_back(DIGIT_BITS'(quot % radix));
            quot = quot / radix;
        end
        while (quot != 0 && rems.size() < MAX_DIGITS);
        for (int i = rems.size() - 1; i >= 0; i--)
        begin
            r = rems[i];
            if (r < DIGIT_BITS'(10))
                beat.ch = CHAR_ZERO + CHAR_BITS'(r);
            else
                beat.ch = CHAR_ALPHA + CHAR_BITS'(r - DIGIT_BITS'(10));
            beat.last = (i == 0);
            digits_due.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        digit_beat_t want;
        if (m_tvalid && m_tready)
        begin
            if (digits_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected digit beat char=%h last=%b",
                             $time, m_tdata[CHAR_BITS-1:0], m_tlast);
            end
            else
            begin
                want = digits_due.pop_front();
                if (m_tdata[CHAR_BITS-1:0] !== want.ch || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: digit mismatch exp char=%h last=%b got char=%h last=%b",
                                 $time, want.ch, want.last, m_tdata[CHAR_BITS-1:0], m_tlast);
                end
            end
        end
        if (s_tvalid && s_tready)
            predict_digits(s_tdata[VALUE_BITS-1:0], s_tdata[VALUE_BITS +: BASE_BITS]);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && (steady_flow || $urandom_range(0, 99) >= 20);

    task automatic send_item(input logic [VALUE_BITS-1:0] value,
                             input logic [BASE_BITS-1:0] base);
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, base, value};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic test_corner_values();
        send_item('0, BASE_DEFAULT);
        send_item('0, BASE_BITS'(0));
        send_item(VALUE_MAX, BASE_MIN);
        send_item(VALUE_MAX, BASE_MAX);
        send_item(VALUE_MAX, BASE_DEFAULT);
        send_item(VALUE_BITS'(15), BASE_MAX);
        send_item(VALUE_BITS'(1), BASE_BITS'(1));
        send_item(VALUE_BITS'(1234567), BASE_BITS'(17));
        send_item(VALUE_BITS'(99), BASE_BITS'(31));
        send_item(VALUE_BITS'(1) << (VALUE_BITS - 1), BASE_BITS'(3));
        for (int b = 2; b <= 16; b++)
            send_item(VALUE_BITS'($urandom()), BASE_BITS'(b));
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        v = VALUE_BITS'($urandom());
        if ($urandom_range(0, 1))
            v = v >> $urandom_range(0, VALUE_BITS - 1);
        return v;
    endfunction

    function automatic logic [BASE_BITS-1:0] random_base();
        if ($urandom_range(0, 99) < 80)
            return BASE_BITS'($urandom_range(2, 16));
        return BASE_BITS'($urandom_range(0, 31));
    endfunction

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS)
            send_item(random_value(), random_base());
    endtask

    // items offered without gaps, both sides always ready
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        repeat (STEADY_ITEMS)
            send_item(random_value(), random_base());
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        steady_flow = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_values();
        test_random_mix();
        test_steady_flow();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && digits_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
